/* rtl/core/tfmd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfmd_pkg
// Shared types and constants for the three-frame motion detector.
// ----------------------------------------------------------------------------
package tfmd_pkg;

    localparam int MAX_FRAME_PIXELS = 1048576;
    localparam int CNT_W            = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int PIX_W            = 8;
    localparam int FACTOR_W         = 16;
    localparam int FRM_W            = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_PIXELS);
    localparam logic [FRM_W-1:0] FRM_MAX = {FRM_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Q8      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_LEVEL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_FRAMES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES    = 2'd3;

    localparam logic [FACTOR_W-1:0] FACTOR_Q8_RST      = 16'd2253;
    localparam logic [PIX_W-1:0]    DIFF_LEVEL_RST     = 8'd10;
    localparam logic [FRM_W-1:0]    CONFIRM_FRAMES_RST = 8'd2;
    localparam logic [FRM_W-1:0]    HOLD_FRAMES_RST    = 8'd60;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor_q8;
        logic [PIX_W-1:0]    diff_level;
        logic [FRM_W-1:0]    confirm_frames;
        logic [FRM_W-1:0]    hold_frames;
    } t_cfg;

    // One finished frame, passed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             calibrate;
    } t_frame_rec;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage
`default_nettype wire

/* rtl/core/three_frame_motion_detector.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_frame_motion_detector
// Result path: last pixel item, frame queue, then the result register when free.
// Throughput: one pixel item per cycle, stalled only while the four-entry frame
// queue is full; the back retires one frame per cycle while results are taken.
// Reset: synchronous, active low; clears counters, baseline, recording
// state and the queue, and loads the register reset values.
// ----------------------------------------------------------------------------
// Front: per-pixel three-frame difference and saturating frame count.
// Queue: finished frame records, so either side can stall on its own.
// Back:  baseline, 21x16 threshold multiply and compare, confirm and hold
//        counters, and the result register.
// ----------------------------------------------------------------------------
module three_frame_motion_detector import tfmd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: pixel_oldest[7:0], pixel_middle[15:8], pixel_newest[23:16]
    input  wire logic [23:0]           s_axis_tdata,
    input  wire logic                  s_axis_tlast,   // frame_end
    input  wire logic                  s_axis_tuser,   // calibrate
    // frame result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: motion_pixels[20:0], over_threshold[21], motion_confirmed[22],
    //        recording[23], recording_ended[24], zero[31:25]
    output logic [31:0]                m_axis_tdata
);

    t_cfg        r_cfg;
    t_queue_stat qstat;
    t_frame_rec  push_rec, pop_rec;
    logic        push, pop;
    logic [CNT_W-1:0] motion_pixels;
    logic        over_threshold, motion_confirmed, recording, recording_ended;

    // Register file: user writes only while the block is idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.factor_q8      <= FACTOR_Q8_RST;
            r_cfg.diff_level     <= DIFF_LEVEL_RST;
            r_cfg.confirm_frames <= CONFIRM_FRAMES_RST;
            r_cfg.hold_frames    <= HOLD_FRAMES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FACTOR_Q8:      r_cfg.factor_q8      <= i_cfg_data;
                REG_DIFF_LEVEL:     r_cfg.diff_level     <= i_cfg_data[PIX_W-1:0];
                REG_CONFIRM_FRAMES: r_cfg.confirm_frames <= i_cfg_data[FRM_W-1:0];
                REG_HOLD_FRAMES:    r_cfg.hold_frames    <= i_cfg_data[FRM_W-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // Classify pixels and count; push one record on each frame end
    tfmd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_diff_level   (r_cfg.diff_level),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_pixel_oldest (s_axis_tdata[7:0]),
        .i_pixel_middle (s_axis_tdata[15:8]),
        .i_pixel_newest (s_axis_tdata[23:16]),
        .i_frame_end    (s_axis_tlast),
        .i_calibrate    (s_axis_tuser),
        .i_qstat        (qstat),
        .o_push         (push),
        .o_rec          (push_rec)
    );

    // Decouple pixel intake from frame decisions
    tfmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (pop_rec),
        .o_stat  (qstat)
    );

    // Decide each frame and hold the result until taken
    tfmd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_qstat            (qstat),
        .i_rec              (pop_rec),
        .o_pop              (pop),
        .o_valid            (m_axis_tvalid),
        .i_ready            (m_axis_tready),
        .o_motion_pixels    (motion_pixels),
        .o_over_threshold   (over_threshold),
        .o_motion_confirmed (motion_confirmed),
        .o_recording        (recording),
        .o_recording_ended  (recording_ended)
    );

    // Pack the result fields, lowest first, zero-filled to 32 bits
    assign m_axis_tdata = {7'd0, recording_ended, recording, motion_confirmed,
                           over_threshold, motion_pixels};

endmodule
`default_nettype wire

/* rtl/core/tfmd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfmd_front
// Classifies each pixel item and counts motion pixels over the frame.
// ----------------------------------------------------------------------------
module tfmd_front import tfmd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [PIX_W-1:0] i_diff_level,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [PIX_W-1:0] i_pixel_oldest,
    input  wire logic [PIX_W-1:0] i_pixel_middle,
    input  wire logic [PIX_W-1:0] i_pixel_newest,
    input  wire logic             i_frame_end,
    input  wire logic             i_calibrate,
    input  wire t_queue_stat      i_qstat,
    output logic                  o_push,
    output t_frame_rec            o_rec
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [PIX_W-1:0] d_new, d_old, anded;
    logic             hit, accept;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] total;

    always_comb begin
        d_new  = (i_pixel_newest > i_pixel_middle) ? i_pixel_newest - i_pixel_middle
                                                   : i_pixel_middle - i_pixel_newest;
        d_old  = (i_pixel_middle > i_pixel_oldest) ? i_pixel_middle - i_pixel_oldest
                                                   : i_pixel_oldest - i_pixel_middle;
        anded  = d_new & d_old;
        hit    = anded > i_diff_level;
        sum    = {1'b0, r_count} + {{CNT_W{1'b0}}, hit};
        total  = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];
        o_ready = !i_qstat.full;
        accept = i_valid && o_ready;
        o_push = accept && i_frame_end;
        o_rec.count     = total;
        o_rec.calibrate = i_calibrate;
        n_count = r_count;
        if (accept) begin
            n_count = i_frame_end ? '0 : total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/tfmd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfmd_queue
// Short first-in first-out queue of finished frame records.
// ----------------------------------------------------------------------------
module tfmd_queue import tfmd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_frame_rec i_rec,
    input  wire logic       i_pop,
    output t_frame_rec      o_rec,
    output t_queue_stat     o_stat
);

    t_frame_rec            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]     r_fill;
    logic                  do_push, do_pop;

    always_comb begin
        o_stat.full  = (r_fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
        o_stat.empty = (r_fill == '0);
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        o_rec        = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/tfmd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfmd_back
// Frame decision: baseline, threshold, confirm and hold, output register.
// ----------------------------------------------------------------------------
module tfmd_back import tfmd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire t_queue_stat i_qstat,
    input  wire t_frame_rec  i_rec,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [CNT_W-1:0] o_motion_pixels,
    output logic             o_over_threshold,
    output logic             o_motion_confirmed,
    output logic             o_recording,
    output logic             o_recording_ended
);

    localparam int PROD_W = CNT_W + FACTOR_W;

    logic [CNT_W-1:0]  r_baseline, n_baseline;
    logic              r_have_base, n_have_base;
    logic [FRM_W-1:0]  r_confirm, n_confirm;
    logic [FRM_W-1:0]  r_hold, n_hold;
    logic              r_rec, n_rec;
    logic              r_valid;
    logic [CNT_W-1:0]  r_pix;
    logic              r_over, r_conf, r_ended;

    logic [PROD_W-1:0] limit, scaled;
    logic [FRM_W-1:0]  cc_inc, hc_inc;
    logic              cal, over, conf, ended;

    always_comb begin
        o_pop  = !i_qstat.empty && (!r_valid || i_ready);
        limit  = PROD_W'(r_baseline) * PROD_W'(i_cfg.factor_q8);
        scaled = PROD_W'({i_rec.count, 8'd0});
        cal    = !r_have_base || i_rec.calibrate;
        over   = !cal && (scaled > limit);
        cc_inc = (r_confirm < FRM_MAX) ? r_confirm + 1'b1 : r_confirm;
        hc_inc = (r_hold < FRM_MAX) ? r_hold + 1'b1 : r_hold;

        n_baseline  = r_baseline;
        n_have_base = r_have_base;
        n_confirm   = r_confirm;
        n_hold      = r_hold;
        n_rec       = r_rec;
        conf        = 1'b0;
        ended       = 1'b0;
        if (cal) begin
            n_baseline  = i_rec.count;
            n_have_base = 1'b1;
        end
        if (over) begin
            n_confirm = cc_inc;
            if (cc_inc >= i_cfg.confirm_frames) begin
                n_hold    = '0;
                n_rec     = 1'b1;
                n_confirm = '0;
                conf      = 1'b1;
            end
        end else if (r_rec) begin
            n_hold = hc_inc;
            if (hc_inc >= i_cfg.hold_frames) begin
                n_hold = '0;
                n_rec  = 1'b0;
                ended  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline  <= '0;
            r_have_base <= 1'b0;
            r_confirm   <= '0;
            r_hold      <= '0;
            r_rec       <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_baseline  <= n_baseline;
                r_have_base <= n_have_base;
                r_confirm   <= n_confirm;
                r_hold      <= n_hold;
                r_rec       <= n_rec;
                r_valid     <= 1'b1;
            end else if (i_ready) begin
                r_valid     <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each decision
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pix   <= i_rec.count;
            r_over  <= over;
            r_conf  <= conf;
            r_ended <= ended;
        end
    end

    always_comb begin
        o_valid            = r_valid;
        o_motion_pixels    = r_pix;
        o_over_threshold   = r_over;
        o_motion_confirmed = r_conf;
        o_recording_ended  = r_ended;
        o_recording        = r_rec;
    end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-frame motion detector. A queue of pixel
// items feeds a bursty stream driver; a transaction-level predictor models the
// per-pixel difference, the frame count, baseline, threshold, confirm and
// hold logic, and the monitor checks every frame result against it.
// ----------------------------------------------------------------------------
module tb_top;
    import tfmd_pkg::*;

    localparam int LONG_HOLD    = 300;   // cycles the receiver holds off once
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result is checked
    localparam int FIFO_LIMIT   = 64;    // keep the pending queue short
    localparam int MAX_REPORTS  = 10;

    // One pixel position seen in three consecutive frames
    typedef struct packed {
        logic [PIX_W-1:0] oldest;
        logic [PIX_W-1:0] middle;
        logic [PIX_W-1:0] newest;
        logic             last;
        logic             cal;
    } pixel_item_t;

    // Frame result as laid out on the output tdata, MSB first
    typedef struct packed {
        logic [6:0]       pad;
        logic             ended;
        logic             rec;
        logic             confirmed;
        logic             over;
        logic [CNT_W-1:0] pixels;
    } frame_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;   // oldest[7:0], middle[15:8], newest[23:16]
    logic                  s_axis_tlast  = 1'b0; // frame_end
    logic                  s_axis_tuser  = 1'b0; // calibrate
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;  // pixels[20:0], over[21], confirmed[22],
                                          // recording[23], ended[24], zero[31:25]

    always #1 i_clk = ~i_clk;

    three_frame_motion_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the registers and frame logic
    // ------------------------------------------------------------------------
    logic [FACTOR_W-1:0] m_factor     = FACTOR_Q8_RST;
    logic [PIX_W-1:0]    m_diff_level = DIFF_LEVEL_RST;
    logic [FRM_W-1:0]    m_confirm    = CONFIRM_FRAMES_RST;
    logic [FRM_W-1:0]    m_hold       = HOLD_FRAMES_RST;

    logic [CNT_W-1:0]    px_count     = '0;
    logic [CNT_W-1:0]    base_count   = '0;
    logic                have_base    = 1'b0;
    logic [FRM_W-1:0]    confirm_cnt  = '0;
    logic [FRM_W-1:0]    hold_cnt     = '0;
    logic                is_rec       = 1'b0;

    pixel_item_t   pixel_fifo[$];   // items waiting for the driver
    frame_result_t exp_frames[$];   // predicted frame results, oldest first

    int n_items, n_frames, n_results, n_over, n_confirm, n_ended;
    int mismatch_count;

    // Control shared by the stimulus process and the two stream processes
    logic idle_en   = 1'b1;
    int   hold_reqs = 0;

    // Advance the model by one accepted pixel item; queue a result on frame end
    function automatic void predict_pixel(pixel_item_t it);
        logic [PIX_W-1:0] d_nm, d_mo, anded;
        logic [CNT_W:0]   sum;
        logic [CNT_W-1:0] total;
        frame_result_t    r;
        d_nm  = (it.newest > it.middle) ? it.newest - it.middle : it.middle - it.newest;
        d_mo  = (it.middle > it.oldest) ? it.middle - it.oldest : it.oldest - it.middle;
        anded = d_nm & d_mo;
        sum   = {1'b0, px_count} + (anded > m_diff_level);
        total = (sum > CNT_MAX) ? CNT_MAX : sum[CNT_W-1:0];
        n_items++;
        if (!it.last) begin
            px_count = total;
            return;
        end
        px_count = '0;
        r        = '0;
        r.pixels = total;
        // Calibration frame: first after reset, or flagged on its last pixel
        if (!have_base || it.cal) begin
            base_count = total;
            have_base  = 1'b1;
        end else begin
            r.over = (longint'(total) * 256) > (longint'(base_count) * longint'(m_factor));
        end
        if (r.over) begin
            if (confirm_cnt != FRM_MAX) confirm_cnt++;
            if (confirm_cnt >= m_confirm) begin
                hold_cnt    = '0;
                is_rec      = 1'b1;
                confirm_cnt = '0;
                r.confirmed = 1'b1;
            end
        end else if (is_rec) begin
            if (hold_cnt != FRM_MAX) hold_cnt++;
            if (hold_cnt >= m_hold) begin
                hold_cnt = '0;
                is_rec   = 1'b0;
                r.ended  = 1'b1;
            end
        end
        r.rec = is_rec;
        n_frames++;
        n_over    += r.over;
        n_confirm += r.confirmed;
        n_ended   += r.ended;
        exp_frames.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer pending items in bursts with random gaps between them
    // ------------------------------------------------------------------------
    pixel_item_t cur_item;
    int          burst_left;
    int          gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // Hand the item just accepted to the predictor
            if (s_axis_tvalid && s_axis_tready) predict_pixel(cur_item);
            // Slot free: idle out the gap, load the next item, or drop valid
            if (!s_axis_tvalid || s_axis_tready) begin
                if (idle_en && gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_fifo.size() != 0) begin
                    cur_item = pixel_fifo.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_item.newest, cur_item.middle, cur_item.oldest};
                    s_axis_tlast  <= cur_item.last;
                    s_axis_tuser  <= cur_item.cal;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: periodic ready pattern with random period and duty, or steady ready
    // if idle_en is low; long hold-off on request fills the frame queue, stalls the input
    // ------------------------------------------------------------------------
    int rx_tick, rx_period, rx_open;
    int hold_left, holds_served;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_tick      = 0;
            rx_period    = 1;
            rx_open      = 1;
            hold_left    = 0;
            holds_served = 0;
        end else if (holds_served != hold_reqs) begin
            holds_served = holds_served + 1;
            hold_left    = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!idle_en) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (rx_tick >= rx_period) begin
                rx_tick   = 0;
                rx_period = $urandom_range(1, 16);
                rx_open   = $urandom_range(0, rx_period);
            end
            m_axis_tready <= (rx_tick < rx_open);
            rx_tick++;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest prediction
    // ------------------------------------------------------------------------
    frame_result_t got, want;

    function automatic void report_mismatch(string what, frame_result_t w, frame_result_t g);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %0s: expected pixels=%0d over=%0b conf=%0b rec=%0b end=%0b pad=%h,",
                     $realtime, what, w.pixels, w.over, w.confirmed, w.rec, w.ended, w.pad,
                     " got pixels=%0d over=%0b conf=%0b rec=%0b end=%0b pad=%h",
                     g.pixels, g.over, g.confirmed, g.rec, g.ended, g.pad);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            n_results++;
            if (exp_frames.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = exp_frames.pop_front();
                if (got.pixels !== want.pixels || got.over !== want.over ||
                    got.confirmed !== want.confirmed || got.rec !== want.rec ||
                    got.ended !== want.ended || got.pad !== want.pad)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Hold the producer while the pending queue is full
    task automatic push_item(input pixel_item_t it);
        while (pixel_fifo.size() >= FIFO_LIMIT) @(negedge i_clk);
        pixel_fifo.push_back(it);
    endtask

    // Wait until every item is accepted and every result checked, then let
    // the pipeline settle before touching the registers
    task automatic wait_idle();
        while (pixel_fifo.size() != 0 || s_axis_tvalid || exp_frames.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_FACTOR_Q8:      m_factor     = val;
            REG_DIFF_LEVEL:     m_diff_level = val[PIX_W-1:0];
            REG_CONFIRM_FRAMES: m_confirm    = val[FRM_W-1:0];
            REG_HOLD_FRAMES:    m_hold       = val[FRM_W-1:0];
            default: ;
        endcase
    endtask

    // Write all four registers; junk in the upper bits of the byte registers
    // must be dropped by the block
    task automatic set_config(input logic [15:0] factor, input logic [7:0] level,
                              input logic [7:0] confirm, input logic [7:0] hold);
        write_reg(REG_FACTOR_Q8, factor);
        write_reg(REG_DIFF_LEVEL, {8'($urandom), level});
        write_reg(REG_CONFIRM_FRAMES, {8'($urandom), confirm});
        write_reg(REG_HOLD_FRAMES, {8'($urandom), hold});
    endtask

    // Queue one frame; motion pixels are built against the current level,
    // the rest are either at or below it or fully random
    task automatic gen_frame(input int len, input int motion_pct, input bit cal_last);
        pixel_item_t it;
        int          d;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < motion_pct && m_diff_level != 8'hFF) begin
                d = $urandom_range(int'(m_diff_level) + 1, 255);
                it.oldest = 8'($urandom_range(0, 255 - d));
                it.middle = 8'(it.oldest + d);
                it.newest = it.oldest;
            end else if ($urandom_range(0, 1)) begin
                d = $urandom_range(0, int'(m_diff_level));
                it.oldest = 8'($urandom_range(0, 255 - d));
                it.middle = 8'(it.oldest + d);
                it.newest = it.oldest;
            end else begin
                it.oldest = 8'($urandom);
                it.middle = 8'($urandom);
                it.newest = 8'($urandom);
            end
            // Mirror the pixel values; the differences stay the same
            if ($urandom_range(0, 1)) begin
                it.oldest = ~it.oldest;
                it.middle = ~it.middle;
                it.newest = ~it.newest;
            end
            it.last = (i == len - 1);
            it.cal  = it.last ? cal_last : 1'($urandom);
            push_item(it);
        end
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 10;
            2:       return 50;
            3:       return 90;
            default: return 100;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    int          phase_items;
    int          len;
    logic [15:0] r_factor;
    logic [7:0]  r_level, r_confirm, r_hold;

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values. The first frame calibrates regardless of
        // its flag; calibrate on a pixel that is not last must be ignored.
        push_item(pixel_item_t'{8'd0,   8'd255, 8'd0,   1'b0, 1'b1});
        push_item(pixel_item_t'{8'd255, 8'd0,   8'd255, 1'b1, 1'b0});
        // Differences exactly at the level: no motion, recalibrate to zero
        push_item(pixel_item_t'{8'd10,  8'd0,   8'd10,  1'b1, 1'b1});
        // Zero baseline: one motion pixel is enough, twice confirms motion
        push_item(pixel_item_t'{8'd0,   8'd11,  8'd0,   1'b1, 1'b0});
        push_item(pixel_item_t'{8'd0,   8'd255, 8'd0,   1'b1, 1'b0});
        // Large differences whose AND is small: quiet frame while recording
        push_item(pixel_item_t'{8'd0,   8'd15,  8'd240, 1'b0, 1'b0});
        push_item(pixel_item_t'{8'd7,   8'd7,   8'd7,   1'b1, 1'b0});
        wait_idle();

        // Zero factor, level, confirm and hold
        set_config(16'd0, 8'd0, 8'd0, 8'd0);
        push_item(pixel_item_t'{8'd0,   8'd1,   8'd0,   1'b1, 1'b0});
        push_item(pixel_item_t'{8'd5,   8'd5,   8'd5,   1'b1, 1'b0});
        push_item(pixel_item_t'{8'd0,   8'd1,   8'd0,   1'b1, 1'b0});
        push_item(pixel_item_t'{8'd255, 8'd255, 8'd255, 1'b1, 1'b1});
        wait_idle();

        // All registers at their maximum: no pixel can pass the level
        set_config(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        push_item(pixel_item_t'{8'd0,   8'd255, 8'd0,   1'b0, 1'b0});
        push_item(pixel_item_t'{8'd255, 8'd0,   8'd255, 1'b1, 1'b0});
        push_item(pixel_item_t'{8'd255, 8'd0,   8'd255, 1'b1, 1'b1});
        wait_idle();

        // Long calibration frame of motion pixels, run at full rate on
        // both sides, then a short frame against that baseline
        set_config(16'd256, 8'd0, 8'd1, 8'd1);
        idle_en <= 1'b0;
        gen_frame(64, 100, 1'b1);
        wait_idle();
        idle_en <= 1'b1;
        gen_frame(3, 100, 1'b0);
        wait_idle();

        // Random phases, each with its own register setting
        for (int ph = 0; ph < 11; ph++) begin
            case ($urandom_range(0, 3))
                0:       r_factor = 16'd0;
                1:       r_factor = 16'hFFFF;
                2:       r_factor = 16'($urandom_range(0, 2048));
                default: r_factor = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       r_level = 8'd0;
                1:       r_level = 8'hFF;
                2:       r_level = 8'($urandom);
                default: r_level = 8'($urandom_range(0, 40));
            endcase
            case ($urandom_range(0, 4))
                0:       r_confirm = 8'd0;
                1:       r_confirm = 8'hFF;
                2:       r_confirm = 8'd1;
                default: r_confirm = 8'($urandom_range(0, 5));
            endcase
            case ($urandom_range(0, 4))
                0:       r_hold = 8'd0;
                1:       r_hold = 8'hFF;
                2:       r_hold = 8'd1;
                default: r_hold = 8'($urandom_range(0, 8));
            endcase
            set_config(r_factor, r_level, r_confirm, r_hold);

            if (ph == 5) begin
                // Hold off the receiver and offer 40 one-pixel frames so that
                // the block backs up onto its input
                hold_reqs <= hold_reqs + 1;
                repeat (40) gen_frame(1, 50, ($urandom_range(0, 9) == 0));
            end else begin
                phase_items = 0;
                while (phase_items < 150) begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 8);
                    gen_frame(len, pick_pct(), ($urandom_range(0, 9) == 0));
                    phase_items += len;
                end
            end
            wait_idle();
        end

        $display("Covered %0d pixel items in %0d frames, %0d results",
                 n_items, n_frames, n_results);
        $display("Frames over threshold %0d, confirmations %0d, recording ends %0d",
                 n_over, n_confirm, n_ended);
        if (mismatch_count == 0 && exp_frames.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
